### hw/rtl/telemetry_frame_packer_crc16_assert.svh
// Assertion macros shared by the frame packer modules.
`ifndef TELEMETRY_FRAME_PACKER_CRC16_ASSERT_SVH
`define TELEMETRY_FRAME_PACKER_CRC16_ASSERT_SVH

// Checked on every clock edge outside of reset.
`define TFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define TFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/tfp_pkg.sv
// Types, constants and helper functions of the telemetry frame packer.
`timescale 1ns / 1ps
package tfp_pkg;

  localparam int PAYLOAD_LEN = 19;
  localparam int FRAME_LEN   = 24;
  localparam int IDX_W       = $clog2(FRAME_LEN);

  localparam logic [7:0]  SYNC_BYTE0  = 8'h55;
  localparam logic [7:0]  SYNC_BYTE1  = 8'hAA;
  localparam logic [7:0]  LEN_BYTE    = 8'(PAYLOAD_LEN);
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_MSB     = 16'h8000;

  // Byte positions within the frame.
  localparam logic [IDX_W-1:0] IDX_SYNC0    = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_SYNC1    = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_LEN      = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_PL_FIRST = IDX_W'(3);
  localparam logic [IDX_W-1:0] IDX_PL_LAST  = IDX_W'(3 + PAYLOAD_LEN - 1);
  localparam logic [IDX_W-1:0] IDX_CRC_LO   = IDX_W'(3 + PAYLOAD_LEN);
  localparam logic [IDX_W-1:0] IDX_CRC_HI   = IDX_W'(FRAME_LEN - 1);

  typedef struct packed {
    logic [31:0]        timestamp_ms;
    logic [31:0]        freq_hz_x1e4;
    logic [15:0]        tau_ms;
    logic signed [31:0] diode_microvolts;
    logic [7:0]         conv_gain;
    logic [7:0]         status_flags;
    logic signed [15:0] ppm_correction_x1e2;
    logic [7:0]         measure_mode;
  } rec_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } beat_t;

  typedef logic [PAYLOAD_LEN-1:0][7:0] payload_t;

  // Little-endian payload layout of one record.
  function automatic payload_t pack_payload(rec_t r);
    payload_t p;
    p[0]  = r.timestamp_ms[7:0];
    p[1]  = r.timestamp_ms[15:8];
    p[2]  = r.timestamp_ms[23:16];
    p[3]  = r.timestamp_ms[31:24];
    p[4]  = r.freq_hz_x1e4[7:0];
    p[5]  = r.freq_hz_x1e4[15:8];
    p[6]  = r.freq_hz_x1e4[23:16];
    p[7]  = r.freq_hz_x1e4[31:24];
    p[8]  = r.tau_ms[7:0];
    p[9]  = r.tau_ms[15:8];
    p[10] = r.diode_microvolts[7:0];
    p[11] = r.diode_microvolts[15:8];
    p[12] = r.diode_microvolts[23:16];
    p[13] = r.diode_microvolts[31:24];
    p[14] = r.conv_gain;
    p[15] = r.status_flags;
    p[16] = r.ppm_correction_x1e2[7:0];
    p[17] = r.ppm_correction_x1e2[15:8];
    p[18] = r.measure_mode;
    return p;
  endfunction

  // One byte of CRC-16/CCITT-FALSE, MSB first.
  function automatic logic [15:0] crc_byte(logic [15:0] crc_in, logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### hw/rtl/telemetry_frame_packer_crc16.sv
// Top level of the telemetry frame packer with CRC-16/CCITT-FALSE.
`timescale 1ns / 1ps
// The block turns each measurement record into a 24-byte binary frame:
// sync bytes 0x55 and 0xAA, a length byte of 19, the 19-byte little-endian
// payload, then the CRC-16/CCITT-FALSE of the payload, low byte first.
// Input side: a record beat is taken on a clock edge where push is high
// and full is low. A two-record queue in the front end holds the laid-out
// payloads, one of them the frame going out, so one more record can be
// taken while a frame is going out.
// Output side: one frame byte per beat; the oldest byte sits on beat while
// empty is low and leaves on an edge where pop is high. last_byte marks the
// final CRC byte of each frame.
// A record taken into an idle block is first written into the front-end
// queue; its first frame byte is then loaded into the output register.
// Throughput: one byte per cycle while pop is held high and a record is
// queued; the serializer has one byte lane and folds in the CRC bytewise.
// When the receiver stalls, the byte waiting in the output register holds
// and the serializer pauses; the front end keeps filling its queue until
// full rises. Reset (synchronous, active high) empties both the queue and
// the output register and restarts framing at the first sync byte.
module telemetry_frame_packer_crc16
  import tfp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  rec_t  rec,
  output logic  empty,
  input  logic  pop,
  output beat_t beat
);

  logic     head_vld;
  payload_t head;
  logic     head_pop;

  // Front end: accept and lay out records.
  tfp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .rec      (rec),
    .head_vld (head_vld),
    .head     (head),
    .head_pop (head_pop)
  );

  // Back end: emit framed bytes with the running CRC.
  tfp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head_vld (head_vld),
    .head     (head),
    .head_pop (head_pop),
    .empty    (empty),
    .pop      (pop),
    .beat     (beat)
  );

endmodule

### hw/rtl/tfp_front.sv
// Front end: accepts records, lays out their payload and queues them.
`timescale 1ns / 1ps
`include "telemetry_frame_packer_crc16_assert.svh"
module tfp_front
  import tfp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  rec_t     rec,
  output logic     head_vld,
  output payload_t head,
  input  logic     head_pop
);

  payload_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push_fire;
  logic       pop_fire;

  assign full      = (count == 2'd2);
  assign head_vld  = (count != 2'd0);
  assign head      = slots[rd_ptr];
  assign push_fire = push && !full;
  assign pop_fire  = head_pop && head_vld;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots[wr_ptr] <= pack_payload(rec);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_fire) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop_fire) begin
        rd_ptr <= !rd_ptr;
      end
      if (push_fire && !pop_fire) begin
        count <= count + 2'd1;
      end else if (pop_fire && !push_fire) begin
        count <= count - 2'd1;
      end
    end
  end

  `TFP_ASSERT(a_count_range, count <= 2'd2, "front queue count out of range")
  `TFP_ASSERT(a_count_ptrs, (count == 2'd1) |-> (wr_ptr != rd_ptr),
              "front queue pointers disagree with count")

endmodule

### hw/rtl/tfp_back.sv
// Back end: serializes the queued payload into frame beats with the CRC.
`timescale 1ns / 1ps
`include "telemetry_frame_packer_crc16_assert.svh"
module tfp_back
  import tfp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     head_vld,
  input  payload_t head,
  output logic     head_pop,
  output logic     empty,
  input  logic     pop,
  output beat_t    beat
);

  logic [IDX_W-1:0] idx;
  logic [15:0]      crc;
  logic             obuf_vld;
  beat_t            obuf;
  logic             load;
  logic             in_payload;
  logic [IDX_W-1:0] pl_idx;
  logic [7:0]       cur_byte;

  assign empty = !obuf_vld;
  assign beat  = obuf;
  assign load  = head_vld && (!obuf_vld || pop);
  assign head_pop = load && (idx == IDX_CRC_HI);

  assign in_payload = (idx inside {[IDX_PL_FIRST:IDX_PL_LAST]});
  assign pl_idx     = idx - IDX_PL_FIRST;

  always_comb begin
    case (idx)
      IDX_SYNC0:  cur_byte = SYNC_BYTE0;
      IDX_SYNC1:  cur_byte = SYNC_BYTE1;
      IDX_LEN:    cur_byte = LEN_BYTE;
      IDX_CRC_LO: cur_byte = crc[7:0];
      IDX_CRC_HI: cur_byte = crc[15:8];
      default:    cur_byte = in_payload ? head[pl_idx] : 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= IDX_SYNC0;
      crc      <= CRC_INIT;
      obuf_vld <= 1'b0;
    end else begin
      if (load) begin
        obuf_vld <= 1'b1;
        if (idx == IDX_CRC_HI) begin
          idx <= IDX_SYNC0;
          crc <= CRC_INIT;
        end else begin
          idx <= idx + IDX_W'(1);
          if (in_payload) begin
            crc <= crc_byte(crc, cur_byte);
          end
        end
      end else if (pop) begin
        obuf_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      obuf.out_byte  <= cur_byte;
      obuf.last_byte <= (idx == IDX_CRC_HI);
    end
  end

  `TFP_ASSERT_ALWAYS(a_idx_range, rst || (idx <= IDX_CRC_HI), "byte index out of frame")
  `TFP_ASSERT(a_crc_fresh, (idx == IDX_SYNC0) |-> (crc == CRC_INIT),
              "CRC not reseeded at frame start")
  `TFP_ASSERT(a_last_wraps, (load && idx == IDX_CRC_HI) |=> (idx == IDX_SYNC0 && obuf.last_byte),
              "last beat did not close the frame")

endmodule
